// ===== rtl/pct_pkg.sv =====
// pct_pkg: shared types and codes for the peer connection table.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package pct_pkg;

  typedef enum logic [1:0] {
    OP_DGRAM   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SWEEP   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_OPENED   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_SWEPT    = 3'd4;

  localparam logic [31:0] IDLE_LIMIT_RESET = 32'd30000;
  localparam logic [3:0]  COUNT_MAX        = 4'd15;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request and slot match masks
    logic commit;   // apply update and load result register
  } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pct_if.sv =====
// pct_req_if / pct_rsp_if: valid/ready channels for requests and results.
// Depends on nothing; instantiated by the user of peer_connection_table_top.
`default_nettype none

interface pct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] src_addr;
  logic [15:0] src_port;
  logic [2:0]  slot_select;
  logic [31:0] now_ms;

  modport source (output valid, operation, src_addr, src_port, slot_select, now_ms,
                  input ready);
  modport sink   (input valid, operation, src_addr, src_port, slot_select, now_ms,
                  output ready);
endinterface

interface pct_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] slot_index;
  logic [2:0] status;
  logic [3:0] freed_count;
  logic [3:0] active_count;

  modport source (output valid, slot_index, status, freed_count, active_count,
                  input ready);
  modport sink   (input valid, slot_index, status, freed_count, active_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/pct_ctrl.sv =====
// pct_ctrl: request sequencer and result valid for the connection table.
// Depends on pct_pkg; drives the command struct of pct_datapath.
`default_nettype none

module pct_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      pct_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free     = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.capture = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.commit  = (state_q == S_COMMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_COMMIT;
          if (out_ready_i) out_valid_q <= 1'b0;
        end
        S_COMMIT: begin
          // wait here while the previous result is still unclaimed
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pct_datapath.sv =====
// pct_datapath: slot registers, parallel match/idle compare and result register.
// Depends on pct_pkg; sequenced by pct_ctrl through pct_pkg::ctl_cmd_t.
`default_nettype none

module pct_datapath #(
  parameter int SLOTS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pct_pkg::ctl_cmd_t cmd_i,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  input  wire logic [1:0]        operation_i,
  input  wire logic [31:0]       src_addr_i,
  input  wire logic [15:0]       src_port_i,
  input  wire logic [2:0]        slot_select_i,
  input  wire logic [31:0]       now_ms_i,
  output      logic [2:0]        slot_index_o,
  output      logic [2:0]        status_o,
  output      logic [3:0]        freed_count_o,
  output      logic [3:0]        active_count_o
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW  = (IW > 3) ? IW : 3;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int CWX = (CW > 4) ? CW : 4;

  // slot state
  logic [SLOTS-1:0] used_q, used_d;
  logic [CW-1:0]    active_q, active_d;
  logic [31:0]      slot_addr_q [SLOTS];
  logic [15:0]      slot_port_q [SLOTS];
  logic [31:0]      slot_seen_q [SLOTS];
  logic [31:0]      limit_q;

  // captured request and masks
  pct_pkg::op_e     op_q;
  logic [31:0]      addr_q;
  logic [15:0]      port_q;
  logic [2:0]       sel_q;
  logic [31:0]      now_q;
  logic [SLOTS-1:0] hit_q, expire_q;
  logic [SLOTS-1:0] hit_m, expire_m;

  // commit logic
  logic [SLOTS-1:0] free_m, rel_m, freed_m, open_m;
  logic [IW-1:0]    hit_idx, free_idx;
  logic             any_hit, any_free;
  logic [CW-1:0]    freed_cnt;
  logic [2:0]       status_d;
  logic [SW-1:0]    idx_d;
  logic [CWX-1:0]   freed_x, active_x;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_m[i]    = used_q[i] && (slot_addr_q[i] == src_addr_i)
                    && (slot_port_q[i] == src_port_i);
      expire_m[i] = used_q[i] && ((now_ms_i - slot_seen_q[i]) >= limit_q);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    free_m   = ~used_q;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_q[i])  hit_idx  = IW'(i);
      if (free_m[i]) free_idx = IW'(i);
      rel_m[i] = used_q[i] && (SW'(sel_q) == SW'(i));
    end
    any_hit  = |hit_q;
    any_free = |free_m;
  end

  always_comb begin
    freed_m  = '0;
    open_m   = '0;
    idx_d    = '0;
    status_d = pct_pkg::ST_SWEPT;
    case (op_q)
      pct_pkg::OP_DGRAM: begin
        if (any_hit) begin
          idx_d    = SW'(hit_idx);
          status_d = pct_pkg::ST_FOUND;
        end else if (any_free) begin
          idx_d            = SW'(free_idx);
          open_m[free_idx] = 1'b1;
          status_d         = pct_pkg::ST_OPENED;
        end else begin
          status_d = pct_pkg::ST_FULL;
        end
      end
      pct_pkg::OP_RELEASE: begin
        freed_m  = rel_m;
        status_d = pct_pkg::ST_RELEASED;
      end
      pct_pkg::OP_SWEEP: freed_m = expire_q;
      pct_pkg::OP_CLEAR: freed_m = used_q;
      default: freed_m = '0;
    endcase
  end

  always_comb begin
    freed_cnt = '0;
    for (int i = 0; i < SLOTS; i++) freed_cnt = freed_cnt + CW'(freed_m[i]);
    used_d   = (used_q & ~freed_m) | open_m;
    active_d = active_q - freed_cnt + CW'(|open_m);
    freed_x  = CWX'(freed_cnt);
    active_x = CWX'(active_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      active_q <= '0;
      limit_q  <= pct_pkg::IDLE_LIMIT_RESET;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        used_q   <= used_d;
        active_q <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= pct_pkg::op_e'(operation_i);
      addr_q   <= src_addr_i;
      port_q   <= src_port_i;
      sel_q    <= slot_select_i;
      now_q    <= now_ms_i;
      hit_q    <= hit_m;
      expire_q <= expire_m;
    end
    if (cmd_i.commit) begin
      if (op_q == pct_pkg::OP_DGRAM) begin
        if (any_hit) begin
          slot_seen_q[hit_idx] <= now_q;
        end else if (any_free) begin
          slot_addr_q[free_idx] <= addr_q;
          slot_port_q[free_idx] <= port_q;
          slot_seen_q[free_idx] <= now_q;
        end
      end
      slot_index_o   <= idx_d[2:0];
      status_o       <= status_d;
      freed_count_o  <= (freed_x > CWX'(pct_pkg::COUNT_MAX)) ? pct_pkg::COUNT_MAX
                                                               : freed_x[3:0];
      active_count_o <= (active_x > CWX'(pct_pkg::COUNT_MAX)) ? pct_pkg::COUNT_MAX
                                                                : active_x[3:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/peer_connection_table_top.sv =====
// peer_connection_table_top: connection slot pool keyed by IPv4 address and port.
// Depends on pct_pkg, pct_if.sv, pct_ctrl and pct_datapath.
//
//   channel  dir  handshake       payload
//   req_i    in   valid/ready     operation, src_addr, src_port, slot_select, now_ms
//   rsp_o    out  valid/ready     slot_index, status, freed_count, active_count
//   cfg      in   cfg_we_i        cfg_wdata_i -> idle_limit_ms
//
// A request is accepted by an edge that latches it with the per-slot address/port
// match and idle compare; a commit edge then updates the slots and loads the result
// register, waiting while the previous result is unclaimed. A new request is
// taken once the commit is done. The result register waits for rsp_o.ready; a
// stalled result holds the commit of the following request. Reset frees all
// slots at once and loads the idle limit with 30000 ms.
`default_nettype none

module peer_connection_table_top #(
  parameter int SLOTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  pct_req_if.sink          req_i,
  pct_rsp_if.source        rsp_o
);

  pct_pkg::ctl_cmd_t cmd;

  pct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  pct_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (req_i.operation),
    .src_addr_i     (req_i.src_addr),
    .src_port_i     (req_i.src_port),
    .slot_select_i  (req_i.slot_select),
    .now_ms_i       (req_i.now_ms),
    .slot_index_o   (rsp_o.slot_index),
    .status_o       (rsp_o.status),
    .freed_count_o  (rsp_o.freed_count),
    .active_count_o (rsp_o.active_count)
  );

endmodule

`default_nettype wire

// ===== dv/tb_peer_connection_table_top.sv =====
// tb_peer_connection_table_top: self-checking bench for the peer connection table.
// Depends on pct_pkg, pct_req_if/pct_rsp_if and peer_connection_table_top; requests go
// through a queue-fed driver, and results are checked against an in-bench slot model.
module tb_peer_connection_table_top;

  localparam int          SLOTS       = 8;
  localparam int          PEERS       = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    pct_pkg::op_e operation;
    logic [31:0]  src_addr;
    logic [15:0]  src_port;
    logic [2:0]   slot_select;
    logic [31:0]  now_ms;
  } request_t;

  typedef struct {
    logic [2:0] slot_index;
    logic [2:0] status;
    logic [3:0] freed_count;
    logic [3:0] active_count;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  pct_req_if req_if ();
  pct_rsp_if rsp_if ();

  peer_connection_table_top #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk = ~clk;

  // slot model
  logic        conn_live [SLOTS];
  logic [31:0] conn_addr [SLOTS];
  logic [15:0] conn_port [SLOTS];
  logic [31:0] conn_seen [SLOTS];
  logic [31:0] idle_limit;

  request_t    request_queue[$];
  result_t     expected_results[$];
  logic [31:0] peer_pool_addr [PEERS];
  logic [15:0] peer_pool_port [PEERS];
  logic [31:0] wall_ms;
  logic        fast_phase;
  logic        req_fire;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned cycle_count;
  int unsigned error_count;

  function automatic logic [3:0] clamp_count(int unsigned n);
    return (n > 15) ? pct_pkg::COUNT_MAX : 4'(n);
  endfunction

  function automatic result_t track_connection(request_t r);
    result_t     res;
    int          hit;
    int unsigned freed;
    int unsigned active;
    logic [31:0] idle_for;
    res = '{slot_index: 3'd0, status: pct_pkg::ST_FOUND, freed_count: 4'd0,
            active_count: 4'd0};
    hit = -1;
    freed = 0;
    active = 0;
    case (r.operation)
      pct_pkg::OP_DGRAM: begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && conn_live[i] && conn_addr[i] == r.src_addr &&
              conn_port[i] == r.src_port)
            hit = i;
        if (hit >= 0) begin
          conn_seen[hit] = r.now_ms;
          res.status = pct_pkg::ST_FOUND;
          res.slot_index = 3'(hit);
        end else begin
          // miss: claim the lowest free slot
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && !conn_live[i]) hit = i;
          if (hit >= 0) begin
            conn_live[hit] = 1'b1;
            conn_addr[hit] = r.src_addr;
            conn_port[hit] = r.src_port;
            conn_seen[hit] = r.now_ms;
            res.status = pct_pkg::ST_OPENED;
            res.slot_index = 3'(hit);
          end else begin
            res.status = pct_pkg::ST_FULL;
          end
        end
      end
      pct_pkg::OP_RELEASE: begin
        if (r.slot_select < SLOTS && conn_live[r.slot_select]) begin
          conn_live[r.slot_select] = 1'b0;
          freed = 1;
        end
        res.status = pct_pkg::ST_RELEASED;
      end
      pct_pkg::OP_SWEEP: begin
        for (int i = 0; i < SLOTS; i++) begin
          idle_for = r.now_ms - conn_seen[i];  // wraps mod 2^32
          if (conn_live[i] && idle_for >= idle_limit) begin
            conn_live[i] = 1'b0;
            freed++;
          end
        end
        res.status = pct_pkg::ST_SWEPT;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++)
          if (conn_live[i]) begin
            conn_live[i] = 1'b0;
            freed++;
          end
        res.status = pct_pkg::ST_SWEPT;
      end
    endcase
    for (int i = 0; i < SLOTS; i++)
      if (conn_live[i]) active++;
    res.freed_count = clamp_count(freed);
    res.active_count = clamp_count(active);
    return res;
  endfunction

  // mostly short gaps, a few long ones; none during a fast phase
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fast_phase || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic request_t random_request(int unsigned step_max);
    request_t    r;
    int unsigned pick;
    int unsigned k;
    r.src_addr = $urandom;
    r.src_port = 16'($urandom);
    r.slot_select = 3'($urandom);
    r.now_ms = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70) r.operation = pct_pkg::OP_DGRAM;
    else if (pick < 80) r.operation = pct_pkg::OP_RELEASE;
    else if (pick < 95) r.operation = pct_pkg::OP_SWEEP;
    else r.operation = pct_pkg::OP_CLEAR;
    if ($urandom_range(0, 99) == 0) wall_ms = $urandom;
    else wall_ms = wall_ms + $urandom_range(0, step_max);
    if (r.operation == pct_pkg::OP_DGRAM || r.operation == pct_pkg::OP_SWEEP)
      r.now_ms = wall_ms;
    // known peers keep hits and a full pool common
    if (r.operation == pct_pkg::OP_DGRAM && $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, PEERS - 1);
      r.src_addr = peer_pool_addr[k];
      r.src_port = peer_pool_port[k];
    end
    return r;
  endfunction

  task automatic push_request(pct_pkg::op_e op, logic [31:0] addr, logic [15:0] port,
                              logic [2:0] sel, logic [31:0] now);
    request_queue.push_back('{operation: op, src_addr: addr, src_port: port,
                              slot_select: sel, now_ms: now});
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_idle_limit(logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    idle_limit = value;
  endtask

  task automatic run_random(int unsigned count, int unsigned step_max, logic fast);
    fast_phase = fast;
    repeat (count) request_queue.push_back(random_request(step_max));
    wait_idle();
    fast_phase = 1'b0;
  endtask

  always @(negedge clk) begin : drive_requests
    request_t item;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      if (send_gap != 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        item = request_queue.pop_front();
        req_if.valid <= 1'b1;
        req_if.operation <= item.operation;
        req_if.src_addr <= item.src_addr;
        req_if.src_port <= item.src_port;
        req_if.slot_select <= item.slot_select;
        req_if.now_ms <= item.now_ms;
        send_gap = draw_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      recv_stall = ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
    end
  end

  always @(posedge clk) begin : watch_channels
    request_t req;
    result_t  want;
    cycle_count++;
    req_fire = 1'b0;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", rsp_if.status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, rsp_if.slot_index);
            error_count++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            error_count++;
          end
          if (rsp_if.freed_count !== want.freed_count) begin
            $error("freed_count: expected %0d, got %0d", want.freed_count,
                   rsp_if.freed_count);
            error_count++;
          end
          if (rsp_if.active_count !== want.active_count) begin
            $error("active_count: expected %0d, got %0d", want.active_count,
                   rsp_if.active_count);
            error_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        req_fire = 1'b1;
        req.operation = pct_pkg::op_e'(req_if.operation);
        req.src_addr = req_if.src_addr;
        req.src_port = req_if.src_port;
        req.slot_select = req_if.slot_select;
        req.now_ms = req_if.now_ms;
        expected_results.push_back(track_connection(req));
      end
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] mid_limit;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 32'd0;
    req_if.valid = 1'b0;
    req_if.operation = pct_pkg::OP_DGRAM;
    req_if.src_addr = 32'd0;
    req_if.src_port = 16'd0;
    req_if.slot_select = 3'd0;
    req_if.now_ms = 32'd0;
    rsp_if.ready = 1'b0;
    fast_phase = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    cycle_count = 0;
    error_count = 0;
    wall_ms = 32'd0;
    idle_limit = pct_pkg::IDLE_LIMIT_RESET;
    for (int i = 0; i < SLOTS; i++) conn_live[i] = 1'b0;
    for (int i = 0; i < PEERS; i++) begin
      peer_pool_addr[i] = $urandom;
      peer_pool_port[i] = 16'($urandom);
    end
    // same address with another port, same port with another address
    peer_pool_addr[1] = peer_pool_addr[0];
    peer_pool_port[2] = peer_pool_port[0];

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: fill, full pool, releases, boundary and wrapped sweeps, clear
    push_request(pct_pkg::OP_CLEAR, 32'd0, 16'd0, 3'd0, 32'd0);
    push_request(pct_pkg::OP_DGRAM, 32'd0, 16'd0, 3'd0, 32'd0);
    push_request(pct_pkg::OP_DGRAM, 32'd0, 16'd0, 3'd0, 32'd5);
    push_request(pct_pkg::OP_DGRAM, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    push_request(pct_pkg::OP_DGRAM, 32'hFFFF_FFFF, 16'd0, 3'd0, 32'd10);
    for (int i = 0; i < 5; i++)
      push_request(pct_pkg::OP_DGRAM, 32'h0A00_0001 + i, 16'd5683, 3'd0, 32'd20);
    push_request(pct_pkg::OP_DGRAM, 32'd0, 16'hFFFF, 3'd0, 32'd20);
    push_request(pct_pkg::OP_DGRAM, 32'hFFFF_FFFF, 16'hFFFF, 3'd0, 32'd25);
    push_request(pct_pkg::OP_RELEASE, 32'd0, 16'd0, 3'd7, 32'd0);
    push_request(pct_pkg::OP_RELEASE, 32'd0, 16'd0, 3'd7, 32'd0);
    push_request(pct_pkg::OP_DGRAM, 32'd0, 16'hFFFF, 3'd0, 32'd29999);
    push_request(pct_pkg::OP_SWEEP, 32'd0, 16'd0, 3'd0, 32'd30005);
    push_request(pct_pkg::OP_SWEEP, 32'd0, 16'd0, 3'd0, 32'd30010);
    push_request(pct_pkg::OP_SWEEP, 32'd0, 16'd0, 3'd0, 32'd30009);
    push_request(pct_pkg::OP_DGRAM, 32'd0, 16'd0, 3'd0, 32'hFFFF_FFF0);
    push_request(pct_pkg::OP_SWEEP, 32'd0, 16'd0, 3'd0, 32'd29984);
    push_request(pct_pkg::OP_RELEASE, 32'd0, 16'd0, 3'd0, 32'd0);
    push_request(pct_pkg::OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    push_request(pct_pkg::OP_RELEASE, 32'd0, 16'd0, 3'd0, 32'd0);
    wait_idle();

    wall_ms = $urandom;
    run_random(250, 8000, 1'b0);

    write_idle_limit(32'd1);
    run_random(150, 3, 1'b1);

    // largest limit frees only at a full-scale difference
    write_idle_limit(32'hFFFF_FFFF);
    push_request(pct_pkg::OP_CLEAR, 32'd0, 16'd0, 3'd0, 32'd0);
    push_request(pct_pkg::OP_DGRAM, peer_pool_addr[3], peer_pool_port[3], 3'd0,
                 32'h0000_0100);
    push_request(pct_pkg::OP_SWEEP, 32'd0, 16'd0, 3'd0, 32'h0000_00FF);
    run_random(100, 1000000, 1'b0);

    // zero limit: every sweep empties the pool
    write_idle_limit(32'd0);
    push_request(pct_pkg::OP_DGRAM, peer_pool_addr[4], peer_pool_port[4], 3'd0, wall_ms);
    push_request(pct_pkg::OP_SWEEP, 32'd0, 16'd0, 3'd0, wall_ms);
    run_random(50, 2, 1'b0);

    mid_limit = $urandom_range(1000, 20000);
    write_idle_limit(mid_limit);
    wall_ms = 32'hFFFF_0000;
    run_random(250, mid_limit / 4, 1'b0);

    write_idle_limit(pct_pkg::IDLE_LIMIT_RESET);
    run_random(200, 6000, 1'b0);

    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== peer_connection_table_top.f =====
rtl/pct_pkg.sv
rtl/pct_if.sv
rtl/pct_ctrl.sv
rtl/pct_datapath.sv
rtl/peer_connection_table_top.sv
dv/tb_peer_connection_table_top.sv
